/* hw/rtl/arc_pkg.sv */
package arc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int LEVEL_W    = 15;
    localparam int CURV_W     = 16;
    localparam int QUOT_W     = 16;
    localparam int MANT_W     = 31;
    localparam int SQRT_STEPS = 31;
    localparam int IPART_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CURVATURE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SATURATION = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRRORED   = 3'd5;

    localparam logic [1:0] REGION_MIN   = 2'd0;
    localparam logic [1:0] REGION_CURVE = 2'd1;
    localparam logic [1:0] REGION_MAX   = 2'd2;

    // per-request sideband carried alongside the datapath
    typedef struct packed {
        logic               flip;
        logic               early;
        logic [1:0]         region;
        logic [LEVEL_W-1:0] y;
    } side_t;

endpackage

/* hw/rtl/axis_response_curve.sv */
// Throughput: one request per cycle; the whole pipeline advances together
// and stalls only while the output register holds a result not taken.
// Most of the depth is the exp2 stage chain: one root bit per cycle when
// not stalled, one round of root stages per fraction bit. Reset is
// synchronous, active low; it clears valid bits and loads the register defaults.
module axis_response_curve #(
    parameter int LOG_STEPS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [arc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [15:0]             s_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [15:0]             m_shaped,
    output logic [1:0]                     m_region
);
    import arc_pkg::*;

    localparam int LW = LOG_STEPS + 4;
    localparam int EW = LOG_STEPS + IPART_W;

    logic [CURV_W-1:0]  curvature_reg;
    logic [LEVEL_W-1:0] min_level_reg;
    logic [LEVEL_W-1:0] max_level_reg;
    logic [LEVEL_W-1:0] dead_zone_reg;
    logic [LEVEL_W-1:0] saturation_reg;
    logic               mirrored_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curvature_reg  <= CURV_W'(4096);
            min_level_reg  <= '0;
            max_level_reg  <= '1;
            dead_zone_reg  <= '0;
            saturation_reg <= '1;
            mirrored_reg   <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CURVATURE:  curvature_reg  <= cfg_wdata;
                CFG_MIN_LEVEL:  min_level_reg  <= cfg_wdata[LEVEL_W-1:0];
                CFG_MAX_LEVEL:  max_level_reg  <= cfg_wdata[LEVEL_W-1:0];
                CFG_DEAD_ZONE:  dead_zone_reg  <= cfg_wdata[LEVEL_W-1:0];
                CFG_SATURATION: saturation_reg <= cfg_wdata[LEVEL_W-1:0];
                CFG_MIRRORED:   mirrored_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic               en;
    logic [LEVEL_W-1:0] range;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign range   = max_level_reg - min_level_reg;

    // front: magnitude and early clamps
    logic               neg;
    logic               flip;
    logic [15:0]        mag;
    side_t              f_side_next;
    logic               f_valid_reg;
    side_t              f_side_reg;
    logic [LEVEL_W-1:0] f_diff_reg;
    logic [15:0]        f_diff_next;

    assign neg  = s_sample[15];
    assign flip = mirrored_reg && neg;
    assign f_diff_next = mag - {1'b0, min_level_reg};

    always_comb begin
        if (flip) begin
            mag = 16'd0 - s_sample;
        end else if (neg) begin
            mag = '0;
        end else begin
            mag = s_sample;
        end
        f_side_next.flip = flip;
        priority if (mag <= {1'b0, dead_zone_reg} || mag <= {1'b0, min_level_reg}) begin
            f_side_next.early  = 1'b1;
            f_side_next.region = REGION_MIN;
            f_side_next.y      = min_level_reg;
        end else if (mag >= {1'b0, max_level_reg}) begin
            f_side_next.early  = 1'b1;
            f_side_next.region = REGION_MAX;
            f_side_next.y      = max_level_reg;
        end else begin
            f_side_next.early  = 1'b0;
            f_side_next.region = REGION_CURVE;
            f_side_next.y      = min_level_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (en) begin
            f_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_side_reg <= f_side_next;
            f_diff_reg <= f_diff_next[LEVEL_W-1:0];
        end
    end

    logic              d_valid;
    side_t             d_side;
    logic [QUOT_W-1:0] d_quot;

    arc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid_reg),
        .in_side   (f_side_reg),
        .in_diff   (f_diff_reg),
        .range     (range),
        .out_valid (d_valid),
        .out_side  (d_side),
        .out_quot  (d_quot)
    );

    logic                 lg_valid;
    side_t                lg_side;
    logic [3:0]           lg_p;
    logic [LOG_STEPS-1:0] lg_frac;

    arc_log2 #(
        .LOG_STEPS (LOG_STEPS)
    ) u_log2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid),
        .in_side   (d_side),
        .in_t      (d_quot),
        .out_valid (lg_valid),
        .out_side  (lg_side),
        .out_p     (lg_p),
        .out_frac  (lg_frac)
    );

    // L = -log2(t), then E = L * curvature >> 12
    logic              l_valid_reg;
    side_t             l_side_reg;
    logic [LW-1:0]     l_reg;
    logic [LW-1:0]     l_next;
    logic [4:0]        ipos;
    logic              e_valid_reg;
    side_t             e_side_reg;
    logic [EW-1:0]     e_reg;
    logic [LW+CURV_W-1:0] e_prod;

    assign ipos   = 5'd16 - {1'b0, lg_p};
    assign l_next = {ipos[3:0], {LOG_STEPS{1'b0}}} - {4'd0, lg_frac};
    assign e_prod = l_reg * curvature_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else if (en) begin
            l_valid_reg <= lg_valid;
            e_valid_reg <= l_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            l_side_reg <= lg_side;
            l_reg      <= l_next;
            e_side_reg <= l_side_reg;
            e_reg      <= e_prod[LW+CURV_W-1:12];
        end
    end

    logic               x_valid;
    side_t              x_side;
    logic [MANT_W-1:0]  x_root;
    logic [IPART_W-1:0] x_ipart;

    arc_exp2 #(
        .LOG_STEPS (LOG_STEPS)
    ) u_exp2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (e_valid_reg),
        .in_side   (e_side_reg),
        .in_e      (e_reg),
        .out_valid (x_valid),
        .out_side  (x_side),
        .out_root  (x_root),
        .out_ipart (x_ipart)
    );

    // integer part shift, scale by range, final clamp and mirror
    logic                      p_valid_reg;
    side_t                     p_side_reg;
    logic [MANT_W-1:0]         pw_reg;
    logic [MANT_W-1:0]         pw_next;
    logic [MANT_W+LEVEL_W-1:0] scaled;
    logic                      y_valid_reg;
    side_t                     y_side_reg;
    logic [15:0]               y_reg;
    logic [15:0]               y_next;

    assign pw_next = (x_ipart >= IPART_W'(31)) ? '0 : (x_root >> x_ipart[4:0]);
    assign scaled  = pw_reg * range;
    assign y_next  = {1'b0, min_level_reg} + scaled[MANT_W+LEVEL_W-1:30];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            y_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg <= x_valid;
            y_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_side_reg <= x_side;
            pw_reg     <= pw_next;
            y_side_reg <= p_side_reg;
            y_reg      <= y_next;
        end
    end

    logic [15:0] res_y;
    logic [1:0]  res_region;
    logic [15:0] shaped_next;
    logic        m_valid_reg;
    logic [15:0] m_shaped_reg;
    logic [1:0]  m_region_reg;

    always_comb begin
        priority if (y_side_reg.early) begin
            res_y      = {1'b0, y_side_reg.y};
            res_region = y_side_reg.region;
        end else if (y_reg <= {1'b0, min_level_reg} || y_reg <= {1'b0, dead_zone_reg}) begin
            res_y      = {1'b0, min_level_reg};
            res_region = REGION_MIN;
        end else if (y_reg >= {1'b0, saturation_reg} || y_reg >= {1'b0, max_level_reg}) begin
            res_y      = {1'b0, max_level_reg};
            res_region = REGION_MAX;
        end else begin
            res_y      = y_reg;
            res_region = REGION_CURVE;
        end
        shaped_next = y_side_reg.flip ? (16'd0 - res_y) : res_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= y_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_shaped_reg <= shaped_next;
            m_region_reg <= res_region;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_shaped = m_shaped_reg;
    assign m_region = m_region_reg;

endmodule

/* hw/rtl/arc_div.sv */
module arc_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  arc_pkg::side_t              in_side,
    input  logic [arc_pkg::LEVEL_W-1:0] in_diff,
    input  logic [arc_pkg::LEVEL_W-1:0] range,
    output logic                        out_valid,
    output arc_pkg::side_t              out_side,
    output logic [arc_pkg::QUOT_W-1:0]  out_quot
);
    import arc_pkg::*;

    logic               valid_reg [QUOT_W];
    side_t              side_reg  [QUOT_W];
    logic [LEVEL_W-1:0] rem_reg   [QUOT_W];
    logic [QUOT_W-1:0]  quot_reg  [QUOT_W];

    genvar s;
    generate
        for (s = 0; s < QUOT_W; s++) begin : g_stage
            logic               valid_src;
            side_t              side_src;
            logic [LEVEL_W-1:0] rem_src;
            logic [QUOT_W-1:0]  quot_src;
            logic [LEVEL_W:0]   shifted;
            logic [LEVEL_W:0]   sub;
            logic               ge;
            logic [LEVEL_W-1:0] rem_next;
            logic [QUOT_W-1:0]  quot_next;

            if (s == 0) begin : g_first
                assign valid_src = in_valid;
                assign side_src  = in_side;
                assign rem_src   = in_diff;
                assign quot_src  = '0;
            end else begin : g_rest
                assign valid_src = valid_reg[s-1];
                assign side_src  = side_reg[s-1];
                assign rem_src   = rem_reg[s-1];
                assign quot_src  = quot_reg[s-1];
            end

            assign shifted   = {rem_src, 1'b0};
            assign sub       = shifted - {1'b0, range};
            assign ge        = shifted >= {1'b0, range};
            assign rem_next  = ge ? sub[LEVEL_W-1:0] : shifted[LEVEL_W-1:0];
            assign quot_next = {quot_src[QUOT_W-2:0], ge};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[s] <= 1'b0;
                end else if (en) begin
                    valid_reg[s] <= valid_src;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    side_reg[s] <= side_src;
                    rem_reg[s]  <= rem_next;
                    quot_reg[s] <= quot_next;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[QUOT_W-1];
    assign out_side  = side_reg[QUOT_W-1];
    assign out_quot  = quot_reg[QUOT_W-1];

endmodule

/* hw/rtl/arc_log2.sv */
module arc_log2 #(
    parameter int LOG_STEPS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  arc_pkg::side_t             in_side,
    input  logic [arc_pkg::QUOT_W-1:0] in_t,
    output logic                       out_valid,
    output arc_pkg::side_t             out_side,
    output logic [3:0]                 out_p,
    output logic [LOG_STEPS-1:0]       out_frac
);
    import arc_pkg::*;

    localparam int NST = LOG_STEPS + 1;

    logic                 valid_reg [NST];
    side_t                side_reg  [NST];
    logic [MANT_W-1:0]    m_reg     [NST];
    logic [LOG_STEPS-1:0] frac_reg  [NST];
    logic [3:0]           p_reg     [NST];

    // normalize: t = 2^p * m, m in Q1.30
    logic [3:0]        p_next;
    logic [MANT_W-1:0] m_next;

    always_comb begin
        p_next = '0;
        for (int i = 0; i < QUOT_W; i++) begin
            if (in_t[i]) begin
                p_next = 4'(i);
            end
        end
        m_next = MANT_W'(in_t) << (5'd30 - {1'b0, p_next});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            m_reg[0]    <= m_next;
            p_reg[0]    <= p_next;
            frac_reg[0] <= '0;
        end
    end

    genvar s;
    generate
        for (s = 1; s < NST; s++) begin : g_sq
            logic [2*MANT_W-1:0]  sq;
            logic [MANT_W:0]      m2;
            logic [MANT_W-1:0]    mq_next;
            logic [LOG_STEPS-1:0] frac_next;

            assign sq        = m_reg[s-1] * m_reg[s-1];
            assign m2        = sq[2*MANT_W-1:MANT_W-1];
            assign mq_next   = m2[MANT_W] ? m2[MANT_W:1] : m2[MANT_W-1:0];
            assign frac_next = {frac_reg[s-1][LOG_STEPS-2:0], m2[MANT_W]};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[s] <= 1'b0;
                end else if (en) begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    side_reg[s] <= side_reg[s-1];
                    m_reg[s]    <= mq_next;
                    p_reg[s]    <= p_reg[s-1];
                    frac_reg[s] <= frac_next;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[NST-1];
    assign out_side  = side_reg[NST-1];
    assign out_p     = p_reg[NST-1];
    assign out_frac  = frac_reg[NST-1];

endmodule

/* hw/rtl/arc_exp2.sv */
module arc_exp2 #(
    parameter int LOG_STEPS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  arc_pkg::side_t              in_side,
    input  logic [LOG_STEPS+7:0]        in_e,
    output logic                        out_valid,
    output arc_pkg::side_t              out_side,
    output logic [arc_pkg::MANT_W-1:0]  out_root,
    output logic [arc_pkg::IPART_W-1:0] out_ipart
);
    import arc_pkg::*;

    localparam int NST = LOG_STEPS * SQRT_STEPS;
    localparam int EW  = LOG_STEPS + IPART_W;
    localparam int NW  = 2 * SQRT_STEPS;
    localparam int RW  = MANT_W + 3;

    logic              valid_reg [NST];
    side_t             side_reg  [NST];
    logic [EW-1:0]     e_reg     [NST];
    logic [NW-1:0]     n_reg     [NST];
    logic [RW-1:0]     rem_reg   [NST];
    logic [MANT_W-1:0] root_reg  [NST];

    genvar s;
    generate
        for (s = 0; s < NST; s++) begin : g_stage
            localparam int R = s / SQRT_STEPS;
            localparam int K = s % SQRT_STEPS;

            logic              valid_src;
            side_t             side_src;
            logic [EW-1:0]     e_src;
            logic [NW-1:0]     n_src;
            logic [RW-1:0]     rem_src;
            logic [MANT_W-1:0] root_src;
            logic [RW-1:0]     rem_sh;
            logic [RW-1:0]     trial;
            logic              ge;
            logic [RW-1:0]     rem_next;
            logic [MANT_W-1:0] root_next;
            logic [NW-1:0]     n_next;

            if (s == 0) begin : g_first
                assign valid_src = in_valid;
                assign side_src  = in_side;
                assign e_src     = in_e;
            end else begin : g_rest
                assign valid_src = valid_reg[s-1];
                assign side_src  = side_reg[s-1];
                assign e_src     = e_reg[s-1];
            end

            // each round: optional halve, then v = isqrt(v << 30)
            if (K == 0) begin : g_load
                logic [MANT_W-1:0] v_base;
                logic [MANT_W-1:0] v_half;

                if (s == 0) begin : g_init
                    assign v_base = MANT_W'(1) << 30;
                end else begin : g_prev
                    assign v_base = root_reg[s-1];
                end

                assign v_half   = e_src[R] ? (v_base >> 1) : v_base;
                assign n_src    = {1'b0, v_half, 30'd0};
                assign rem_src  = '0;
                assign root_src = '0;
            end else begin : g_cont
                assign n_src    = n_reg[s-1];
                assign rem_src  = rem_reg[s-1];
                assign root_src = root_reg[s-1];
            end

            assign rem_sh    = {rem_src[RW-3:0], n_src[NW-1:NW-2]};
            assign trial     = {1'b0, root_src, 2'b01};
            assign ge        = rem_sh >= trial;
            assign rem_next  = ge ? (rem_sh - trial) : rem_sh;
            assign root_next = {root_src[MANT_W-2:0], ge};
            assign n_next    = {n_src[NW-3:0], 2'b00};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[s] <= 1'b0;
                end else if (en) begin
                    valid_reg[s] <= valid_src;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    side_reg[s] <= side_src;
                    e_reg[s]    <= e_src;
                    n_reg[s]    <= n_next;
                    rem_reg[s]  <= rem_next;
                    root_reg[s] <= root_next;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[NST-1];
    assign out_side  = side_reg[NST-1];
    assign out_root  = root_reg[NST-1];
    assign out_ipart = e_reg[NST-1][EW-1:LOG_STEPS];

endmodule

/* tb/response_curve_checker.sv */
`timescale 1ns / 1ps

module response_curve_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [arc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic signed [15:0]             s_sample,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic signed [15:0]             m_shaped,
    input  logic [1:0]                     m_region,
    output int                             errors,
    output int                             pending
);
    import arc_pkg::*;

    localparam int FRAC_BITS = 16;

    typedef struct packed {
        logic [15:0] shaped;
        logic [1:0]  region;
    } shaped_t;

    logic [15:0] curv;
    logic [14:0] lo_lvl, hi_lvl, dz_lvl, sat_lvl;
    logic        mirror;
    shaped_t     expected_q[$];

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] minus_log2(logic [63:0] t);
        int          p;
        logic [63:0] m, frac;
        p = 15;
        frac = 0;
        while (p > 0 && t[p] == 1'b0) p--;
        m = t << (30 - p);
        for (int i = 0; i < FRAC_BITS; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return (64'(16 - p) << FRAC_BITS) - frac;
    endfunction

    function automatic logic [63:0] pow2_neg(logic [63:0] e);
        logic [63:0] ipart, v;
        ipart = e >> FRAC_BITS;
        v = 64'd1 << 30;
        for (int i = 0; i < FRAC_BITS; i++) begin
            if (e[i]) v = v >> 1;
            v = int_sqrt(v << 30);
        end
        if (ipart >= 31) return 0;
        return v >> ipart;
    endfunction

    function automatic shaped_t shape_sample(logic [15:0] raw);
        shaped_t     r;
        logic        neg, flip;
        logic [63:0] x, y, span, t, e;
        neg = raw[15];
        flip = mirror && neg;
        if (flip) x = 64'h10000 - raw;
        else x = neg ? 0 : raw;
        if (x <= dz_lvl || x <= lo_lvl) begin
            y = lo_lvl;
            r.region = REGION_MIN;
        end else if (x >= hi_lvl) begin
            y = hi_lvl;
            r.region = REGION_MAX;
        end else begin
            span = hi_lvl - lo_lvl;
            t = ((x - lo_lvl) << 16) / span;
            e = (minus_log2(t) * curv) >> 12;
            y = lo_lvl + ((pow2_neg(e) * span) >> 30);
            if (y <= lo_lvl || y <= dz_lvl) begin
                y = lo_lvl;
                r.region = REGION_MIN;
            end else if (y >= sat_lvl || y >= hi_lvl) begin
                y = hi_lvl;
                r.region = REGION_MAX;
            end else begin
                r.region = REGION_CURVE;
            end
        end
        if (flip) y = (64'h10000 - y) & 64'hFFFF;
        r.shaped = y[15:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        errors++;
    endtask

    initial errors = 0;
    assign pending = expected_q.size();

    always @(posedge aclk) begin
        shaped_t want;
        if (!aresetn) begin
            curv <= 16'd4096;
            lo_lvl <= 15'd0;
            hi_lvl <= 15'd32767;
            dz_lvl <= 15'd0;
            sat_lvl <= 15'd32767;
            mirror <= 1'b1;
            expected_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_CURVATURE: curv <= cfg_wdata;
                    CFG_MIN_LEVEL: lo_lvl <= cfg_wdata[14:0];
                    CFG_MAX_LEVEL: hi_lvl <= cfg_wdata[14:0];
                    CFG_DEAD_ZONE: dz_lvl <= cfg_wdata[14:0];
                    CFG_SATURATION: sat_lvl <= cfg_wdata[14:0];
                    CFG_MIRRORED: mirror <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) expected_q.push_back(shape_sample(s_sample));
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = expected_q.pop_front();
                    if (m_shaped !== want.shaped)
                        report_mismatch($sformatf("shaped got %0d want %0d",
                            m_shaped, $signed(want.shaped)));
                    if (m_region !== want.region)
                        report_mismatch($sformatf("region got %0d want %0d",
                            m_region, want.region));
                end
            end
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import arc_pkg::*;

    localparam int LATENCY = 23 + 32 * 16;

    logic                  aclk, aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid, s_ready, m_valid, m_ready;
    logic signed [15:0]    s_sample, m_shaped;
    logic [1:0]            m_region;
    int                    errors, pending;
    bit                    send_gaps;
    bit                    hold_req;
    logic [14:0]           lvl_lo, lvl_hi, lvl_dz;

    axis_response_curve uut (.*);
    response_curve_checker chk (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request, one stretch always ready
    initial begin
        int cyc, hold;
        bit hold_done;
        cyc = 0;
        hold = 0;
        hold_done = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (hold_req && !hold_done) begin
                hold = 1500;
                hold_done = 1;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (cyc >= 6000 && cyc < 8000) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(99) >= 38);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[15:0];
        @(posedge aclk);
    endtask

    task automatic set_levels(input int curv_v, lo, hi, dz, sat, mir);
        write_reg(CFG_CURVATURE, curv_v);
        write_reg(CFG_MIN_LEVEL, lo);
        write_reg(CFG_MAX_LEVEL, hi);
        write_reg(CFG_DEAD_ZONE, dz);
        write_reg(CFG_SATURATION, sat);
        write_reg(CFG_MIRRORED, mir);
        cfg_we <= 1'b0;
        lvl_lo = lo[14:0];
        lvl_hi = hi[14:0];
        lvl_dz = dz[14:0];
    endtask

    task automatic send(input int v);
        s_valid <= 1'b1;
        s_sample <= v[15:0];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (send_gaps && $urandom_range(99) < 38) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
    endtask

    task automatic run_phase(input int count);
        int lv[6];
        int v, pick;
        lv = '{0, lvl_lo, lvl_hi, lvl_dz, 32767, 1};
        foreach (lv[i]) begin
            send(lv[i]);
            send(-lv[i]);
            send(lv[i] + 1);
        end
        send(-32768);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(3);
            if (pick == 0) v = $signed(16'($urandom));
            else v = $urandom_range(lvl_lo, lvl_hi > lvl_lo ? lvl_hi : lvl_lo);
            if (pick >= 2) v = -v;
            send(v);
        end
        drain();
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_sample <= '0;
        send_gaps = 1;
        hold_req = 0;
        lvl_lo = 0;
        lvl_hi = 32767;
        lvl_dz = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_phase(20);
        set_levels(0, 1000, 30000, 500, 32767, 1);
        run_phase(20);
        set_levels(65535, 0, 32767, 0, 32767, 0);
        run_phase(30);
        set_levels(8192, 32767, 0, 0, 32767, 1);
        run_phase(15);
        set_levels(2048, 2000, 31000, 32767, 0, 1);
        run_phase(15);
        send_gaps = 0;
        set_levels(12288, 3000, 28000, 4000, 26000, 1);
        run_phase(40);
        send_gaps = 1;
        set_levels(2048, 100, 32000, 200, 31000, 0);
        // long receiver hold-off while the sender keeps offering
        hold_req = 1;
        run_phase(330);
        for (int k = 0; k < 3; k++) begin
            set_levels($urandom_range(1024, 32768), $urandom_range(0, 8000),
                $urandom_range(20000, 32767), $urandom_range(0, 10000),
                $urandom_range(16000, 32767), $urandom_range(1));
            run_phase(15);
        end
        set_levels($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        run_phase(10);

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
